// ----- rtl/dbp_pkg.sv -----
// dbp_pkg: shared types and op codes for the Deflate bit packer.
// No dependencies; imported by every rtl module of the block.
package dbp_pkg;

	localparam logic [2:0] OP_HUFF  = 3'd0;
	localparam logic [2:0] OP_DATA  = 3'd1;
	localparam logic [2:0] OP_BYTE1 = 3'd2;
	localparam logic [2:0] OP_BYTE2 = 3'd3;
	localparam logic [2:0] OP_BYTE4 = 3'd4;

	localparam logic [5:0] MAX_BITS = 6'd32;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [2:0]  op;
		logic [5:0]  bit_count;
		logic [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	// normalized work: bits LSB first, count 1..32, aligned flag
	typedef struct packed {
		logic [31:0] bits;
		logic [5:0]  nbits;
		logic        align;
	} entry_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		logic [1:0] count;
	} queue_stat_t;

endpackage

// ----- rtl/dbp_front.sv -----
// dbp_front: classifies an input beat into a normalized queue entry.
// Depends on dbp_pkg.
module dbp_front (
	input  dbp_pkg::in_item_t in_item,
	output dbp_pkg::entry_t   ent,
	output logic              keep
);
	import dbp_pkg::*;

	logic [5:0]  n_sat;
	logic [31:0] rev;
	logic [31:0] mask;
	logic [5:0]  rsh;

	always_comb begin
		n_sat = (in_item.bit_count > MAX_BITS) ? MAX_BITS : in_item.bit_count;
		for (int i = 0; i < 32; i++) begin
			rev[i] = in_item.value[31 - i];
		end
		rsh  = MAX_BITS - n_sat;
		mask = (n_sat == MAX_BITS) ? 32'hFFFF_FFFF : ((32'd1 << n_sat[4:0]) - 32'd1);
		ent  = '0;
		keep = 1'b0;
		case (in_item.op)
			OP_HUFF: begin
				ent.bits  = (n_sat == 6'd0) ? 32'd0 : (rev >> rsh[4:0]);
				ent.nbits = n_sat;
				keep      = (n_sat != 6'd0);
			end
			OP_DATA: begin
				ent.bits  = in_item.value & mask;
				ent.nbits = n_sat;
				keep      = (n_sat != 6'd0);
			end
			OP_BYTE1: begin
				ent.bits  = {24'd0, in_item.value[7:0]};
				ent.nbits = 6'd8;
				ent.align = 1'b1;
				keep      = 1'b1;
			end
			OP_BYTE2: begin
				ent.bits  = {16'd0, in_item.value[15:0]};
				ent.nbits = 6'd16;
				ent.align = 1'b1;
				keep      = 1'b1;
			end
			OP_BYTE4: begin
				ent.bits  = in_item.value;
				ent.nbits = 6'd32;
				ent.align = 1'b1;
				keep      = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/dbp_queue.sv -----
// dbp_queue: two-entry queue between classifier and packer.
// Depends on dbp_pkg.
module dbp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dbp_pkg::entry_t       push_ent,
	input  logic                  pop,
	output dbp_pkg::entry_t       head,
	output dbp_pkg::queue_stat_t  stat
);
	import dbp_pkg::*;

	entry_t     mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == 2'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == 2'd0);
	assign stat.count = cnt_q;

endmodule

// ----- rtl/dbp_back.sv -----
// dbp_back: merges entries into the bit accumulator and emits bytes.
// Depends on dbp_pkg.
module dbp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ent_valid,
	input  dbp_pkg::entry_t     ent,
	output logic                ent_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output dbp_pkg::out_item_t  out_item
);
	import dbp_pkg::*;

	// window of pending bits; below 8 bits it is the partial byte
	logic [39:0] w_q;
	logic [5:0]  cnt_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        have_byte;
	logic        emit;
	logic [39:0] w_load;
	logic [5:0]  cnt_load;

	assign have_byte = (cnt_q[5:3] != 3'd0);
	assign emit      = have_byte && (!out_valid_q || out_ready);
	assign ent_pop   = !have_byte && ent_valid;

	always_comb begin
		if (ent.align && (cnt_q[2:0] != 3'd0)) begin
			w_load   = {ent.bits, 1'b0, w_q[6:0]};
			cnt_load = ent.nbits + 6'd8;
		end else if (ent.align) begin
			w_load   = {8'd0, ent.bits};
			cnt_load = ent.nbits;
		end else begin
			w_load   = {33'd0, w_q[6:0]} | ({8'd0, ent.bits} << cnt_q[2:0]);
			cnt_load = {3'd0, cnt_q[2:0]} + ent.nbits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ent_pop) begin
				w_q   <= w_load;
				cnt_q <= cnt_load;
			end else if (emit) begin
				w_q   <= w_q >> 8;
				cnt_q <= cnt_q - 6'd8;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte <= w_q[7:0];
			out_q.last     <= (cnt_q < 6'd16);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ----- rtl/deflate_bit_packer_unit.sv -----
// deflate_bit_packer_unit: top level of the LSB-first Deflate bit packer.
// Depends on dbp_pkg, dbp_front, dbp_queue, dbp_back.
//
//  channel | handshake            | beat
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | in_item: op, bit_count, value
//  out     | out_valid / out_ready| out_item: out_byte, last
//
// An item is first merged into the 40-bit window, then its bytes are
// emitted one per cycle while the output is not stalled. Items with
// no byte take the merge step only; ignored ops never reach the queue.
// A two-entry queue lets input be taken while bytes drain.
// Reset clears the partial byte, the queue pointers and count, and the output valid flag.
// A stalled output holds a window with a full byte; input stalls only when the queue is full.
module deflate_bit_packer_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dbp_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output dbp_pkg::out_item_t  out_item
);
	import dbp_pkg::*;

	entry_t      front_ent;
	logic        keep;
	logic        push;
	logic        pop;
	entry_t      head;
	queue_stat_t qstat;

	dbp_front u_front (
		.in_item (in_item),
		.ent     (front_ent),
		.keep    (keep)
	);

	assign in_ready = !qstat.full;
	assign push     = in_valid && in_ready && keep;

	dbp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (front_ent),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	dbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ent_valid (!qstat.empty),
		.ent       (head),
		.ent_pop   (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= 2'(QUEUE_DEPTH))
		else $error("queue count over depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (qstat.count == $past(qstat.count) + 2'd1))
		else $error("queue count lost a push");

	a_entry_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (front_ent.nbits != 6'd0 && front_ent.nbits <= MAX_BITS))
		else $error("queued entry with bad bit count");
`endif

endmodule
